@@ src/tlssni_pkg.sv @@
`default_nettype none
// Shared types and constants for the TLS ClientHello server-name extractor.
package tlssni_pkg;

  localparam logic [7:0]  REC_HANDSHAKE   = 8'h16;
  localparam logic [7:0]  HS_CLIENT_HELLO = 8'h01;
  localparam int          PREFIX_LEN      = 43;
  localparam logic [15:0] EXT_SERVER_NAME = 16'h0000;

  localparam logic [8:0]  CAPACITY_RESET  = 9'd256;

  localparam logic KIND_NAME    = 1'b0;
  localparam logic KIND_VERDICT = 1'b1;

  localparam int QUEUE_DEPTH = 4;

  typedef enum logic [3:0] {
    PH_HEADER       = 4'd0,
    PH_SID_LEN      = 4'd1,
    PH_SID_SKIP     = 4'd2,
    PH_CS_HI        = 4'd3,
    PH_CS_LO        = 4'd4,
    PH_CS_SKIP      = 4'd5,
    PH_CM_LEN       = 4'd6,
    PH_CM_SKIP      = 4'd7,
    PH_EXT_TOTAL_HI = 4'd8,
    PH_EXT_TOTAL_LO = 4'd9,
    PH_EXT_HDR      = 4'd10,
    PH_EXT_SKIP     = 4'd11,
    PH_SNI_HDR      = 4'd12,
    PH_NAME         = 4'd13,
    PH_DONE         = 4'd14
  } phase_t;

  typedef struct packed {
    logic       kind;
    logic [7:0] name_char;
    logic       found;
    logic [7:0] copied_len;
    logic       last_of_run;
  } result_t;

  typedef struct packed {
    logic [1:0] cnt;
    result_t    r0;
    result_t    r1;
  } push_t;

endpackage
`default_nettype wire

@@ src/tlssni_parse.sv @@
`default_nettype none
// Input register and per-byte ClientHello parser producing up to two results.
module tlssni_parse #(
  parameter int POSITION_WIDTH = 18
) (
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 item_valid,
  output logic                item_stall,
  input  wire  [7:0]          data_byte,
  input  wire                 end_of_packet,
  input  wire  [8:0]          name_capacity,
  input  wire                 room,
  output tlssni_pkg::push_t   push
);
  import tlssni_pkg::*;

  localparam int W = POSITION_WIDTH;

  logic       in_vld;
  logic [7:0] in_byte;
  logic       in_eop;
  logic       go;
  logic       accept;

  logic [W-1:0] pos, pos_next;
  phase_t       phase, phase_next;
  logic [15:0]  acc, acc_next;
  logic [15:0]  skip, skip_next;
  logic [W-1:0] ext_end, ext_end_next;
  logic [15:0]  ext_code, ext_code_next;
  logic [7:0]   sent, sent_next;
  logic         verdict_done, verdict_done_next;

  logic [W:0]   next_pos;
  logic [7:0]   lim;
  logic         name_emit;
  logic         verdict_now;
  logic         verdict_ok;
  logic         verdict_any;
  result_t      name_res;
  result_t      verd_res;

  assign go         = in_vld && room;
  assign item_stall = in_vld && !go;
  assign accept     = item_valid && !item_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_vld <= 1'b0;
    end else if (accept) begin
      in_vld <= 1'b1;
    end else if (go) begin
      in_vld <= 1'b0;
    end
    if (accept) begin
      in_byte <= data_byte;
      in_eop  <= end_of_packet;
    end
  end

  always_comb begin
    if (name_capacity[8]) begin
      lim = 8'hFF;
    end else if (name_capacity[7:0] == 8'd0) begin
      lim = 8'd0;
    end else begin
      lim = name_capacity[7:0] - 8'd1;
    end
  end

  assign next_pos = {1'b0, pos} + (W+1)'(1);

  always_comb begin
    pos_next          = pos;
    phase_next        = phase;
    acc_next          = acc;
    skip_next         = skip;
    ext_end_next      = ext_end;
    ext_code_next     = ext_code;
    sent_next         = sent;
    verdict_done_next = verdict_done;
    name_emit         = 1'b0;
    verdict_now       = 1'b0;
    verdict_ok        = 1'b0;
    verdict_any       = 1'b0;
    name_res          = '0;
    verd_res          = '0;
    push              = '0;

    if (go) begin
      case (phase)
        PH_HEADER: begin
          if ((pos == W'(0) && in_byte != REC_HANDSHAKE) ||
              (pos == W'(5) && in_byte != HS_CLIENT_HELLO)) begin
            verdict_now = 1'b1;
          end else if (pos >= W'(PREFIX_LEN - 1)) begin
            phase_next = PH_SID_LEN;
          end
        end
        PH_SID_LEN: begin
          skip_next  = {8'd0, in_byte};
          phase_next = (in_byte != 8'd0) ? PH_SID_SKIP : PH_CS_HI;
        end
        PH_SID_SKIP: begin
          if (skip <= 16'd1) begin
            skip_next  = '0;
            phase_next = PH_CS_HI;
          end else begin
            skip_next = skip - 16'd1;
          end
        end
        PH_CS_HI: begin
          acc_next   = {in_byte, 8'd0};
          phase_next = PH_CS_LO;
        end
        PH_CS_LO: begin
          acc_next   = acc | {8'd0, in_byte};
          skip_next  = acc_next;
          phase_next = (acc_next != 16'd0) ? PH_CS_SKIP : PH_CM_LEN;
        end
        PH_CS_SKIP: begin
          if (skip <= 16'd1) begin
            skip_next  = '0;
            phase_next = PH_CM_LEN;
          end else begin
            skip_next = skip - 16'd1;
          end
        end
        PH_CM_LEN: begin
          skip_next  = {8'd0, in_byte};
          phase_next = (in_byte != 8'd0) ? PH_CM_SKIP : PH_EXT_TOTAL_HI;
        end
        PH_CM_SKIP: begin
          if (skip <= 16'd1) begin
            skip_next  = '0;
            phase_next = PH_EXT_TOTAL_HI;
          end else begin
            skip_next = skip - 16'd1;
          end
        end
        PH_EXT_TOTAL_HI: begin
          acc_next   = {in_byte, 8'd0};
          phase_next = PH_EXT_TOTAL_LO;
        end
        PH_EXT_TOTAL_LO: begin
          acc_next = acc | {8'd0, in_byte};
          if (next_pos + (W+1)'(acc_next) > {1'b0, {W{1'b1}}}) begin
            ext_end_next = {W{1'b1}};
          end else begin
            ext_end_next = W'(next_pos + (W+1)'(acc_next));
          end
          if (next_pos + (W+1)'(4) > {1'b0, ext_end_next}) begin
            verdict_now = 1'b1;
          end else begin
            phase_next = PH_EXT_HDR;
            skip_next  = '0;
          end
        end
        PH_EXT_HDR: begin
          if (skip < 16'd2) begin
            ext_code_next = {ext_code[7:0], in_byte};
          end else begin
            acc_next = {acc[7:0], in_byte};
          end
          if (skip >= 16'd3) begin
            if (ext_code_next == EXT_SERVER_NAME) begin
              phase_next = PH_SNI_HDR;
              skip_next  = '0;
            end else if (acc_next == 16'd0) begin
              if (next_pos + (W+1)'(4) > {1'b0, ext_end}) begin
                verdict_now = 1'b1;
              end else begin
                phase_next = PH_EXT_HDR;
                skip_next  = '0;
              end
            end else begin
              skip_next  = acc_next;
              phase_next = PH_EXT_SKIP;
            end
          end else begin
            skip_next = skip + 16'd1;
          end
        end
        PH_EXT_SKIP: begin
          if (skip <= 16'd1) begin
            skip_next = '0;
            if (next_pos + (W+1)'(4) > {1'b0, ext_end}) begin
              verdict_now = 1'b1;
            end else begin
              phase_next = PH_EXT_HDR;
            end
          end else begin
            skip_next = skip - 16'd1;
          end
        end
        PH_SNI_HDR: begin
          if (skip >= 16'd3) begin
            acc_next = {acc[7:0], in_byte};
          end
          if (skip >= 16'd4) begin
            if (acc_next == 16'd0 || lim == 8'd0) begin
              verdict_now = 1'b1;
            end else begin
              skip_next  = acc_next;
              phase_next = PH_NAME;
            end
          end else begin
            skip_next = skip + 16'd1;
          end
        end
        PH_NAME: begin
          if (sent < lim) begin
            name_emit = 1'b1;
            sent_next = sent + 8'd1;
          end
          if (skip <= 16'd1) begin
            skip_next   = '0;
            verdict_now = 1'b1;
            verdict_ok  = (sent_next != 8'd0);
          end else begin
            skip_next = skip - 16'd1;
          end
        end
        default: begin
        end
      endcase

      if (verdict_now) begin
        phase_next        = PH_DONE;
        verdict_done_next = 1'b1;
      end

      pos_next = next_pos[W] ? {W{1'b1}} : next_pos[W-1:0];

      // close the packet with a failure if nothing has been said yet
      verdict_any = verdict_now || (in_eop && !verdict_done_next);

      name_res.kind      = KIND_NAME;
      name_res.name_char = in_byte;

      verd_res.kind        = KIND_VERDICT;
      verd_res.found       = verdict_now && verdict_ok;
      verd_res.copied_len  = sent_next;
      verd_res.last_of_run = 1'b1;

      push.cnt = {1'b0, name_emit} + {1'b0, verdict_any};
      push.r0  = name_emit ? name_res : verd_res;
      push.r1  = verd_res;

      if (in_eop) begin
        pos_next          = '0;
        phase_next        = PH_HEADER;
        acc_next          = '0;
        skip_next         = '0;
        ext_end_next      = '0;
        ext_code_next     = '0;
        sent_next         = '0;
        verdict_done_next = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos          <= '0;
      phase        <= PH_HEADER;
      acc          <= '0;
      skip         <= '0;
      ext_end      <= '0;
      ext_code     <= '0;
      sent         <= '0;
      verdict_done <= 1'b0;
    end else begin
      pos          <= pos_next;
      phase        <= phase_next;
      acc          <= acc_next;
      skip         <= skip_next;
      ext_end      <= ext_end_next;
      ext_code     <= ext_code_next;
      sent         <= sent_next;
      verdict_done <= verdict_done_next;
    end
  end

`ifndef SYNTHESIS
  a_eop_clears: assert property (@(posedge clk) disable iff (rst)
    go && in_eop |=> phase == PH_HEADER && pos == '0 && !verdict_done)
    else $error("packet state not cleared after final byte");

  a_verdict_phase: assert property (@(posedge clk) disable iff (rst)
    verdict_done |-> phase == PH_DONE)
    else $error("verdict given but parser still active");

  a_pair_order: assert property (@(posedge clk) disable iff (rst)
    push.cnt == 2'd2 |-> push.r0.kind == KIND_NAME && push.r1.kind == KIND_VERDICT)
    else $error("two results from one byte not name then verdict");
`endif

endmodule
`default_nettype wire

@@ src/tlssni_queue.sv @@
`default_nettype none
// Result queue taking up to two results per cycle and delivering one when not stalled.
module tlssni_queue (
  input  wire                 clk,
  input  wire                 rst,
  input  tlssni_pkg::push_t   push,
  output logic                room,
  output logic                result_valid,
  input  wire                 result_stall,
  output tlssni_pkg::result_t head
);
  import tlssni_pkg::*;

  localparam int PW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  result_t       q [QUEUE_DEPTH];
  logic [PW-1:0] wp;
  logic [PW-1:0] rp;
  logic [CW-1:0] count;
  logic          pop;

  assign result_valid = (count != '0);
  assign pop          = result_valid && !result_stall;
  assign room         = (count <= CW'(QUEUE_DEPTH - 2));
  assign head         = q[rp];

  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= '0;
      rp    <= '0;
      count <= '0;
    end else begin
      wp    <= wp + PW'(push.cnt);
      rp    <= rp + PW'(pop);
      count <= count + CW'(push.cnt) - CW'(pop);
    end
    if (push.cnt != 2'd0) begin
      q[wp] <= push.r0;
    end
    if (push.cnt == 2'd2) begin
      q[wp + PW'(1)] <= push.r1;
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push.cnt != 2'd0 |-> (count + CW'(push.cnt)) <= CW'(QUEUE_DEPTH))
    else $error("result queue overflow");

  a_hold_count: assert property (@(posedge clk) disable iff (rst)
    !pop && push.cnt == 2'd0 |=> $stable(count))
    else $error("queue fill changed without push or pop");

  a_head_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(head))
    else $error("stalled result changed");
`endif

endmodule
`default_nettype wire

@@ src/tls_client_hello_sni_extractor.sv @@
`default_nettype none
// Top level of the TLS ClientHello server-name extractor.
//
// Takes one payload byte per cycle, with end_of_packet on the final byte,
// and returns the server name bytes followed by one verdict per packet.
// A byte is accepted every cycle while the result queue has room; results
// pass the input register and the queue. The byte that ends the name,
// if copied, or a name byte that is also the packet's final byte, yields
// two results (name byte and verdict), which leave the four-entry queue
// one per unstalled cycle, so the output side sets the sustained rate on
// such bytes. On a failure verdict the consumer drops the name bytes
// already delivered. name_capacity is written through cfg_write_enable
// and cfg_write_data and should change only while the block is idle.
module tls_client_hello_sni_extractor #(
  parameter int POSITION_WIDTH = 18
) (
  input  wire        clk,
  input  wire        rst,
  input  wire        cfg_write_enable,
  input  wire  [8:0] cfg_write_data,
  input  wire        item_valid,
  output logic       item_stall,
  input  wire  [7:0] data_byte,
  input  wire        end_of_packet,
  output logic       result_valid,
  input  wire        result_stall,
  output logic       result_kind,
  output logic [7:0] name_char,
  output logic       found,
  output logic [7:0] copied_len,
  output logic       last_of_run
);
  import tlssni_pkg::*;

  logic [8:0] name_capacity;
  logic       room;
  push_t      push;
  result_t    head;

  always_ff @(posedge clk) begin
    if (rst) begin
      name_capacity <= CAPACITY_RESET;
    end else if (cfg_write_enable) begin
      name_capacity <= cfg_write_data;
    end
  end

  tlssni_parse #(
    .POSITION_WIDTH(POSITION_WIDTH)
  ) u_parse (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .data_byte    (data_byte),
    .end_of_packet(end_of_packet),
    .name_capacity(name_capacity),
    .room         (room),
    .push         (push)
  );

  tlssni_queue u_queue (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .room        (room),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .head        (head)
  );

  assign result_kind = head.kind;
  assign name_char   = head.name_char;
  assign found       = head.found;
  assign copied_len  = head.copied_len;
  assign last_of_run = head.last_of_run;

endmodule
`default_nettype wire
